// ===== rtl/core/hol_pkg.sv =====
`default_nettype none
package hol_pkg;

	localparam logic [7:0] CharNewline = 8'h0A;
	localparam logic [7:0] CharTab     = 8'h09;
	localparam logic [7:0] CharSpace   = 8'h20;
	localparam logic [7:0] CharColon   = 8'h3A;
	localparam logic [7:0] CharUpperE  = 8'h45;
	localparam logic [7:0] CharLowerE  = 8'h65;
	localparam logic [7:0] CharUpperP  = 8'h50;
	localparam logic [7:0] CharLowerP  = 8'h70;

	localparam int WordW      = 12;
	localparam int QueueDepth = 2;

	localparam logic RK_WRITE  = 1'b0;
	localparam logic RK_REPORT = 1'b1;

	typedef struct packed {
		logic       eof;
		logic       newline;
		logic       gap;
		logic       hex;
		logic [3:0] digit;
		logic       letter_e;
		logic       letter_p;
	} hol_word_t;

	typedef enum logic [1:0] {
		DP_ADDR,
		DP_DROP,
		DP_VAL,
		DP_OFF
	} data_phase_t;

	typedef enum logic [2:0] {
		EP_COL0,
		EP_SAWE,
		EP_DROP,
		EP_DIG,
		EP_OFF
	} entry_phase_t;

endpackage
`default_nettype wire

// ===== rtl/core/hol_if.sv =====
`default_nettype none
interface hol_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_file;

	modport source (output valid, output char_code, output end_of_file, input ready);
	modport sink (input valid, input char_code, input end_of_file, output ready);
endinterface

interface hol_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [11:0] write_address;
	logic [11:0] write_data;
	logic [11:0] entry_point;
	logic        entry_found;

	modport source (output valid, output result_kind, output write_address,
		output write_data, output entry_point, output entry_found, input ready);
	modport sink (input valid, input result_kind, input write_address,
		input write_data, input entry_point, input entry_found, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/hex_object_line_loader_top.sv =====
// A result word is registered in the classifier, the queue and the parser output stage.
// Throughput: one character word per cycle while res_out is not stalled, set by the parser.
// A two-entry queue between classifier and parser absorbs output stalls.
// Reset (arst_n low, asynchronous): queue empties, parser returns to column zero,
// no entry point is held and no result is pending.
`default_nettype none
module hex_object_line_loader_top #(
	parameter int HEX_DIGITS = 3
) (
	input  wire       clk,
	input  wire       arst_n,
	hol_in_if.sink    char_in,
	hol_out_if.source res_out
);

	logic               f_valid;
	logic               f_ready;
	hol_pkg::hol_word_t f_word;
	logic               b_valid;
	logic               b_ready;
	hol_pkg::hol_word_t b_word;

	hol_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_word  (f_word)
	);

	hol_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_word  (f_word),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_word   (b_word)
	);

	hol_back #(
		.HEX_DIGITS (HEX_DIGITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_word  (b_word),
		.res_out   (res_out)
	);

endmodule
`default_nettype wire

// ===== rtl/core/hol_front.sv =====
`default_nettype none
module hol_front (
	input  wire              clk,
	input  wire              arst_n,
	hol_in_if.sink           char_in,
	output logic             push_valid,
	input  wire              push_ready,
	output hol_pkg::hol_word_t push_word
);

	hol_pkg::hol_word_t word_s1;
	logic               valid_s1;
	hol_pkg::hol_word_t word_d;
	logic [7:0]         c;

	assign c = char_in.char_code;

	always_comb begin
		word_d          = '0;
		word_d.eof      = char_in.end_of_file;
		word_d.newline  = (c == hol_pkg::CharNewline);
		word_d.gap      = (c == hol_pkg::CharSpace) || (c == hol_pkg::CharTab) ||
			(c == hol_pkg::CharColon);
		word_d.letter_e = (c == hol_pkg::CharUpperE) || (c == hol_pkg::CharLowerE);
		word_d.letter_p = (c == hol_pkg::CharUpperP) || (c == hol_pkg::CharLowerP);
		if (c inside {[8'h30:8'h39]}) begin
			word_d.hex   = 1'b1;
			word_d.digit = 4'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			word_d.hex   = 1'b1;
			word_d.digit = 4'(c - 8'h37);
		end else if (c inside {[8'h61:8'h66]}) begin
			word_d.hex   = 1'b1;
			word_d.digit = 4'(c - 8'h57);
		end
	end

	assign char_in.ready = !valid_s1 || push_ready;
	assign push_valid    = valid_s1;
	assign push_word     = word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.ready) begin
			valid_s1 <= char_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.ready && char_in.valid) begin
			word_s1 <= word_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hol_queue.sv =====
`default_nettype none
module hol_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push_valid,
	output logic               push_ready,
	input  hol_pkg::hol_word_t push_word,
	output logic               pop_valid,
	input  wire                pop_ready,
	output hol_pkg::hol_word_t pop_word
);

	localparam int PtrW = (hol_pkg::QueueDepth > 1) ? $clog2(hol_pkg::QueueDepth) : 1;
	localparam int CntW = $clog2(hol_pkg::QueueDepth + 1);

	hol_pkg::hol_word_t    slot_q [hol_pkg::QueueDepth];
	logic [PtrW-1:0]       wr_ptr_q;
	logic [PtrW-1:0]       rd_ptr_q;
	logic [CntW-1:0]       cnt_q;
	logic                  push;
	logic                  pop;

	assign push_ready = (cnt_q != CntW'(hol_pkg::QueueDepth));
	assign pop_valid  = (cnt_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_word   = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(hol_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(hol_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hol_back.sv =====
`default_nettype none
module hol_back #(
	parameter int HEX_DIGITS = 3
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                pop_valid,
	output logic               pop_ready,
	input  hol_pkg::hol_word_t pop_word,
	hol_out_if.source          res_out
);

	localparam int AccW = 4 * HEX_DIGITS;
	localparam int CntW = (HEX_DIGITS > 1) ? $clog2(HEX_DIGITS) : 1;
	localparam int WW   = hol_pkg::WordW;

	hol_pkg::data_phase_t  dphase_q, dphase_d;
	hol_pkg::entry_phase_t ephase_q, ephase_d;
	logic [CntW-1:0]       dcnt_q, dcnt_d;
	logic [CntW-1:0]       ecnt_q, ecnt_d;
	logic [AccW-1:0]       addr_acc_q, addr_acc_d;
	logic [AccW-1:0]       val_acc_q, val_acc_d;
	logic [AccW-1:0]       ent_acc_q, ent_acc_d;
	logic                  latched_q, latched_d;
	logic [WW-1:0]         entry_reg_q, entry_reg_d;

	logic                  res_v;
	logic                  res_kind;
	logic [WW-1:0]         res_addr;
	logic [WW-1:0]         res_data;
	logic [WW-1:0]         res_entry;
	logic                  res_found;
	logic [AccW+WW-1:0]    ext_a;
	logic [AccW+WW-1:0]    ext_v;
	logic [AccW+WW-1:0]    ext_e;

	logic                  out_v_q;
	logic                  kind_q;
	logic [WW-1:0]         addr_q;
	logic [WW-1:0]         data_q;
	logic [WW-1:0]         entry_q;
	logic                  found_q;
	logic                  pop;

	assign pop_ready = !out_v_q || res_out.ready;
	assign pop       = pop_valid && pop_ready;

	always_comb begin
		dphase_d    = dphase_q;
		ephase_d    = ephase_q;
		dcnt_d      = dcnt_q;
		ecnt_d      = ecnt_q;
		addr_acc_d  = addr_acc_q;
		val_acc_d   = val_acc_q;
		ent_acc_d   = ent_acc_q;
		latched_d   = latched_q;
		entry_reg_d = entry_reg_q;
		res_v       = 1'b0;
		res_kind    = hol_pkg::RK_WRITE;
		res_addr    = '0;
		res_data    = '0;
		res_entry   = '0;
		res_found   = 1'b0;
		ext_a       = {{WW{1'b0}}, addr_acc_q};
		ext_v       = {{WW{1'b0}}, val_acc_q};
		ext_e       = {{WW{1'b0}}, ent_acc_q};

		if (pop_word.eof || pop_word.newline) begin
			dphase_d   = hol_pkg::DP_ADDR;
			ephase_d   = hol_pkg::EP_COL0;
			dcnt_d     = '0;
			ecnt_d     = '0;
			addr_acc_d = '0;
			val_acc_d  = '0;
			ent_acc_d  = '0;
			if (pop_word.eof) begin
				res_v       = 1'b1;
				res_kind    = hol_pkg::RK_REPORT;
				res_entry   = latched_q ? entry_reg_q : '0;
				res_found   = latched_q;
				latched_d   = 1'b0;
				entry_reg_d = '0;
			end
		end else begin
			case (ephase_q)
				hol_pkg::EP_COL0: begin
					ephase_d = pop_word.letter_e ? hol_pkg::EP_SAWE : hol_pkg::EP_OFF;
				end
				hol_pkg::EP_SAWE: begin
					ephase_d = pop_word.letter_p ? hol_pkg::EP_DROP : hol_pkg::EP_OFF;
				end
				hol_pkg::EP_DROP: begin
					ephase_d = hol_pkg::EP_DIG;
				end
				hol_pkg::EP_DIG: begin
					if (ecnt_q == '0 && pop_word.gap) begin
						ephase_d = hol_pkg::EP_DIG;
					end else if (!pop_word.hex) begin
						ephase_d = hol_pkg::EP_OFF;
					end else begin
						ent_acc_d = AccW'({ent_acc_q, pop_word.digit});
						ext_e     = {{WW{1'b0}}, ent_acc_d};
						if (ecnt_q == CntW'(HEX_DIGITS - 1)) begin
							ephase_d = hol_pkg::EP_OFF;
							if (!latched_q && ext_e[AccW+WW-1:WW] == '0) begin
								latched_d   = 1'b1;
								entry_reg_d = ext_e[WW-1:0];
							end
						end else begin
							ecnt_d = ecnt_q + 1'b1;
						end
					end
				end
				default: begin
					ephase_d = hol_pkg::EP_OFF;
				end
			endcase

			case (dphase_q)
				hol_pkg::DP_ADDR: begin
					if (dcnt_q == '0 && pop_word.gap) begin
						dphase_d = hol_pkg::DP_ADDR;
					end else if (!pop_word.hex) begin
						dphase_d = hol_pkg::DP_OFF;
					end else begin
						addr_acc_d = AccW'({addr_acc_q, pop_word.digit});
						if (dcnt_q == CntW'(HEX_DIGITS - 1)) begin
							dphase_d = hol_pkg::DP_DROP;
							dcnt_d   = '0;
						end else begin
							dcnt_d = dcnt_q + 1'b1;
						end
					end
				end
				hol_pkg::DP_DROP: begin
					dphase_d = hol_pkg::DP_VAL;
					dcnt_d   = '0;
				end
				hol_pkg::DP_VAL: begin
					if (dcnt_q == '0 && pop_word.gap) begin
						dphase_d = hol_pkg::DP_VAL;
					end else if (!pop_word.hex) begin
						dphase_d = hol_pkg::DP_OFF;
					end else begin
						val_acc_d = AccW'({val_acc_q, pop_word.digit});
						ext_v     = {{WW{1'b0}}, val_acc_d};
						if (dcnt_q == CntW'(HEX_DIGITS - 1)) begin
							dphase_d = hol_pkg::DP_OFF;
							res_v    = (ext_a[AccW+WW-1:WW] == '0);
							res_addr = ext_a[WW-1:0];
							res_data = ext_v[WW-1:0];
						end else begin
							dcnt_d = dcnt_q + 1'b1;
						end
					end
				end
				default: begin
					dphase_d = hol_pkg::DP_OFF;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dphase_q    <= hol_pkg::DP_ADDR;
			ephase_q    <= hol_pkg::EP_COL0;
			dcnt_q      <= '0;
			ecnt_q      <= '0;
			addr_acc_q  <= '0;
			val_acc_q   <= '0;
			ent_acc_q   <= '0;
			latched_q   <= 1'b0;
			entry_reg_q <= '0;
		end else if (pop) begin
			dphase_q    <= dphase_d;
			ephase_q    <= ephase_d;
			dcnt_q      <= dcnt_d;
			ecnt_q      <= ecnt_d;
			addr_acc_q  <= addr_acc_d;
			val_acc_q   <= val_acc_d;
			ent_acc_q   <= ent_acc_d;
			latched_q   <= latched_d;
			entry_reg_q <= entry_reg_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (pop_ready) begin
			out_v_q <= pop && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && res_v) begin
			kind_q  <= res_kind;
			addr_q  <= res_addr;
			data_q  <= res_data;
			entry_q <= res_entry;
			found_q <= res_found;
		end
	end

	assign res_out.valid         = out_v_q;
	assign res_out.result_kind   = kind_q;
	assign res_out.write_address = addr_q;
	assign res_out.write_data    = data_q;
	assign res_out.entry_point   = entry_q;
	assign res_out.entry_found   = found_q;

endmodule
`default_nettype wire

// ===== rtl/core/hol_checker.sv =====
`default_nettype none
module hol_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        result_kind,
	input wire [11:0] write_address,
	input wire [11:0] write_data,
	input wire [11:0] entry_point,
	input wire        entry_found
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hol_pkg::RK_WRITE |-> entry_point == 12'd0 && !entry_found)
		else $error("write word carries entry fields");

	a_report_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hol_pkg::RK_REPORT |->
			write_address == 12'd0 && write_data == 12'd0)
		else $error("report word carries write fields");

	a_no_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == hol_pkg::RK_REPORT && !entry_found |-> entry_point == 12'd0)
		else $error("entry point set without entry found");

endmodule

bind hex_object_line_loader_top hol_checker u_hol_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (res_out.valid),
	.out_ready     (res_out.ready),
	.result_kind   (res_out.result_kind),
	.write_address (res_out.write_address),
	.write_data    (res_out.write_data),
	.entry_point   (res_out.entry_point),
	.entry_found   (res_out.entry_found)
);
`default_nettype wire
